@@ rtl/lrop_pkg.sv @@
// ----------------------------------------------------------------------------
// lrop_pkg
// shared types and constants of the log record operation parser
// ----------------------------------------------------------------------------
package lrop_pkg;

  localparam int unsigned HASH_BYTES = 8;
  localparam int unsigned HDR_SHORT  = 14;
  localparam int unsigned HDR_LONG   = 25;
  localparam int unsigned MIN_SIZE   = 22;
  localparam int unsigned LONG_SIZE  = 33;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_OP     = 2'd1,
    KIND_OK     = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_DEL      = 2'd1,
    OP_DEL_SPAN = 2'd2,
    OP_PUT_TREE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_PUT      = 2'd0,
    REG_DEL      = 2'd1,
    REG_DEL_SPAN = 2'd2,
    REG_PUT_TREE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SIZE, PH_HDR, PH_TYPE, PH_LEN1, PH_BODY1, PH_LEN2,
    PH_BODY2, PH_VLEN, PH_WORD, PH_TAIL, PH_DROP
  } phase_t;

  typedef struct packed {
    logic [7:0] put_code;
    logic [7:0] del_code;
    logic [7:0] span_code;
    logic [7:0] tree_code;
  } codes_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] sequence_res;
    logic [7:0]  hdr_flags;
    logic [63:0] txn_id;
    logic [15:0] participant_count;
    op_t         op_kind;
    logic [31:0] first_offset;
    logic [15:0] first_length;
    logic [31:0] second_offset;
    logic [31:0] second_length;
    logic [63:0] subtree_word;
    logic [15:0] op_total;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       r0;
    rec_t       r1;
  } push_t;

endpackage

@@ rtl/log_record_op_parser.sv @@
// ----------------------------------------------------------------------------
// log_record_op_parser
// streaming log entry parser emitting header, operation and status records
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries one entry byte per word with
// entry_start marking the first size byte. output channel out_valid/out_ready
// carries one result word: header, operation descriptor, entry ok or bad.
// a byte is taken every cycle while the four-entry result queue has room for
// two words; one byte gives at most two results. the first result of a byte
// is written into the queue and then into the output register, a second one
// behind it. throughput is one byte per cycle as long as the receiver takes a
// word per cycle; when the receiver stalls the queue fills and in_ready drops
// until it drains. type codes are written over the apb port at byte
// addresses 0, 4, 8 and 12. reset (rst, synchronous) empties the queue,
// drops the output word, puts the parser in idle waiting for entry_start,
// and restores the type codes to 0, 1, 2 and 3.
// ----------------------------------------------------------------------------
module log_record_op_parser import lrop_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        entry_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [63:0] sequence_res,
  output logic [7:0]  hdr_flags,
  output logic [63:0] txn_id,
  output logic [15:0] participant_count,
  output logic [1:0]  op_kind,
  output logic [31:0] first_offset,
  output logic [15:0] first_length,
  output logic [31:0] second_offset,
  output logic [31:0] second_length,
  output logic [63:0] subtree_word,
  output logic [15:0] op_total
);

  codes_t codes;
  push_t  push;
  logic   room, head_valid, pop;
  rec_t   head, out_rec;

  assign in_ready = room;

  lrop_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .codes(codes)
  );

  lrop_front u_front (
    .clk(clk), .rst(rst), .codes(codes), .take_word(in_valid && room),
    .in_byte(in_byte), .entry_start(entry_start), .push(push)
  );

  lrop_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .room(room), .head_valid(head_valid),
    .head(head), .pop(pop)
  );

  lrop_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_rec(out_rec)
  );

  assign result_kind       = out_rec.kind;
  assign sequence_res      = out_rec.sequence_res;
  assign hdr_flags         = out_rec.hdr_flags;
  assign txn_id            = out_rec.txn_id;
  assign participant_count = out_rec.participant_count;
  assign op_kind           = out_rec.op_kind;
  assign first_offset      = out_rec.first_offset;
  assign first_length      = out_rec.first_length;
  assign second_offset     = out_rec.second_offset;
  assign second_length     = out_rec.second_length;
  assign subtree_word      = out_rec.subtree_word;
  assign op_total          = out_rec.op_total;

endmodule

@@ rtl/lrop_cfg.sv @@
// ----------------------------------------------------------------------------
// lrop_cfg
// apb register file holding the four operation type codes
// ----------------------------------------------------------------------------
module lrop_cfg import lrop_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output codes_t      codes
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.put_code  <= 8'd0;
      codes.del_code  <= 8'd1;
      codes.span_code <= 8'd2;
      codes.tree_code <= 8'd3;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_PUT:      codes.put_code  <= pwdata[7:0];
        REG_DEL:      codes.del_code  <= pwdata[7:0];
        REG_DEL_SPAN: codes.span_code <= pwdata[7:0];
        REG_PUT_TREE: codes.tree_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PUT:      prdata = {24'd0, codes.put_code};
      REG_DEL:      prdata = {24'd0, codes.del_code};
      REG_DEL_SPAN: prdata = {24'd0, codes.span_code};
      REG_PUT_TREE: prdata = {24'd0, codes.tree_code};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/lrop_front.sv @@
// ----------------------------------------------------------------------------
// lrop_front
// byte parser: tracks entry position and fields, emits up to two records
// ----------------------------------------------------------------------------
module lrop_front import lrop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  codes_t     codes,
  input  logic       take_word,
  input  logic [7:0] in_byte,
  input  logic       entry_start,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [31:0] position, position_next;
  logic [31:0] entry_length, entry_length_next;
  logic [15:0] ops_left, ops_left_next;
  logic [63:0] field_shift, field_shift_next;
  logic [31:0] field_bytes_left, field_bytes_left_next;
  op_t         current_op, current_op_next;
  logic [47:0] held_first_span, held_first_span_next;
  logic [63:0] held_second_span, held_second_span_next;
  logic [63:0] held_sequence, held_sequence_next;
  logic [63:0] held_tx_id, held_tx_id_next;
  logic [23:0] held_flags_count, held_flags_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      position         <= '0;
      entry_length     <= '0;
      ops_left         <= '0;
      field_shift      <= '0;
      field_bytes_left <= '0;
      current_op       <= OP_PUT;
      held_first_span  <= '0;
      held_second_span <= '0;
      held_sequence    <= '0;
      held_tx_id       <= '0;
      held_flags_count <= '0;
    end else if (take_word) begin
      phase            <= phase_next;
      position         <= position_next;
      entry_length     <= entry_length_next;
      ops_left         <= ops_left_next;
      field_shift      <= field_shift_next;
      field_bytes_left <= field_bytes_left_next;
      current_op       <= current_op_next;
      held_first_span  <= held_first_span_next;
      held_second_span <= held_second_span_next;
      held_sequence    <= held_sequence_next;
      held_tx_id       <= held_tx_id_next;
      held_flags_count <= held_flags_count_next;
    end
  end

  phase_t      ph;
  logic [31:0] i;
  logic [33:0] limit;
  logic [31:0] v32;
  logic [15:0] v16;
  logic        fits2, fits4, fits8, fits_v16, fits_v32;
  logic        do_after, do_finish, do_next, do_bad, do_hdr, do_ok;
  logic [63:0] fin_span, fin_word;
  logic [31:0] hdr_end;
  rec_t        rec_a, rec_b, rec_bad;
  logic        have_a;

  always_comb begin
    ph                    = phase;
    position_next         = position;
    entry_length_next     = entry_length;
    ops_left_next         = ops_left;
    field_shift_next      = field_shift;
    field_bytes_left_next = field_bytes_left;
    current_op_next       = current_op;
    held_first_span_next  = held_first_span;
    held_second_span_next = held_second_span;
    held_sequence_next    = held_sequence;
    held_tx_id_next       = held_tx_id;
    held_flags_count_next = held_flags_count;
    do_after  = 1'b0;
    do_finish = 1'b0;
    do_next   = 1'b0;
    do_bad    = 1'b0;
    do_hdr    = 1'b0;
    do_ok     = 1'b0;
    fin_span  = '0;
    fin_word  = '0;
    v16       = '0;
    v32       = '0;

    if (entry_start) begin
      ph                    = PH_SIZE;
      position_next         = '0;
      entry_length_next     = '0;
      ops_left_next         = '0;
      held_sequence_next    = '0;
      held_tx_id_next       = '0;
      held_flags_count_next = '0;
      held_first_span_next  = '0;
      held_second_span_next = '0;
      field_shift_next      = '0;
      field_bytes_left_next = '0;
      current_op_next       = OP_PUT;
    end

    i = position_next;
    if (ph != PH_IDLE && ph != PH_DROP && position_next != 32'hFFFF_FFFF) begin
      position_next = position_next + 32'd1;
    end

    limit   = {2'b00, entry_length_next};
    hdr_end = (entry_length_next >= 32'(LONG_SIZE)) ? 32'(HDR_LONG) : 32'(HDR_SHORT);

    if (ph == PH_LEN1 || ph == PH_LEN2 || ph == PH_VLEN || ph == PH_WORD) begin
      field_shift_next      = {in_byte, field_shift_next[63:8]};
      field_bytes_left_next = field_bytes_left_next - 32'd1;
    end
    v16 = field_shift_next[63:48];
    v32 = field_shift_next[63:32];

    fits2    = ({2'b00, position_next} + 34'd2 + 34'(HASH_BYTES)) <= limit;
    fits4    = ({2'b00, position_next} + 34'd4 + 34'(HASH_BYTES)) <= limit;
    fits8    = ({2'b00, position_next} + 34'd8 + 34'(HASH_BYTES)) <= limit;
    fits_v16 = ({2'b00, position_next} + {18'd0, v16} + 34'(HASH_BYTES)) <= limit;
    fits_v32 = ({2'b00, position_next} + {2'b00, v32} + 34'(HASH_BYTES)) <= limit;

    case (ph)
      PH_SIZE: begin
        entry_length_next = entry_length_next | ({24'd0, in_byte} << {i[1:0], 3'b000});
        if (i >= 32'd3) begin
          if (entry_length_next < 32'(MIN_SIZE)) do_bad = 1'b1;
          else ph = PH_HDR;
        end
      end
      PH_HDR: begin
        if (i >= 32'd4 && i < 32'd12)
          held_sequence_next = held_sequence_next |
                               ({56'd0, in_byte} << {i[2:0] - 3'd4, 3'b000});
        else if (i == 32'd12)
          ops_left_next = {ops_left_next[15:8], in_byte};
        else if (i == 32'd13)
          ops_left_next = {in_byte, ops_left_next[7:0]};
        else if (i == 32'd14)
          held_flags_count_next = {in_byte, held_flags_count_next[15:0]};
        else if (i >= 32'd15 && i < 32'd23)
          held_tx_id_next = held_tx_id_next |
                            ({56'd0, in_byte} << {i[2:0] - 3'd7, 3'b000});
        else if (i == 32'd23)
          held_flags_count_next = {held_flags_count_next[23:8], in_byte};
        else if (i == 32'd24)
          held_flags_count_next = {held_flags_count_next[23:16], in_byte,
                                   held_flags_count_next[7:0]};
        if (position_next == hdr_end) begin
          do_hdr  = 1'b1;
          do_next = 1'b1;
        end
      end
      PH_TYPE: begin
        if (in_byte == codes.put_code || in_byte == codes.del_code ||
            in_byte == codes.span_code || in_byte == codes.tree_code) begin
          if (in_byte == codes.put_code)       current_op_next = OP_PUT;
          else if (in_byte == codes.del_code)  current_op_next = OP_DEL;
          else if (in_byte == codes.span_code) current_op_next = OP_DEL_SPAN;
          else                                 current_op_next = OP_PUT_TREE;
          held_first_span_next  = '0;
          held_second_span_next = '0;
          if (fits2) begin
            field_shift_next      = '0;
            field_bytes_left_next = 32'd2;
            ph                    = PH_LEN1;
          end else begin
            do_after = 1'b1;
          end
        end else begin
          do_bad = 1'b1;
        end
      end
      PH_LEN1: begin
        if (field_bytes_left_next == 32'd0) begin
          if (v16 == 16'd0 || !fits_v16) begin
            do_after = 1'b1;
          end else begin
            held_first_span_next  = {v16, position_next};
            field_bytes_left_next = {16'd0, v16};
            ph                    = PH_BODY1;
          end
        end
      end
      PH_BODY1: begin
        field_bytes_left_next = field_bytes_left_next - 32'd1;
        if (field_bytes_left_next == 32'd0) do_after = 1'b1;
      end
      PH_LEN2: begin
        if (field_bytes_left_next == 32'd0) begin
          if (v16 == 16'd0 || !fits_v16) begin
            do_finish = 1'b1;
          end else begin
            held_second_span_next = {16'd0, v16, position_next};
            field_bytes_left_next = {16'd0, v16};
            ph                    = PH_BODY2;
          end
        end
      end
      PH_VLEN: begin
        if (field_bytes_left_next == 32'd0) begin
          if (!fits_v32) begin
            do_bad = 1'b1;
          end else if (v32 == 32'd0) begin
            do_finish = 1'b1;
          end else begin
            held_second_span_next = {v32, position_next};
            field_bytes_left_next = v32;
            ph                    = PH_BODY2;
          end
        end
      end
      PH_BODY2: begin
        field_bytes_left_next = field_bytes_left_next - 32'd1;
        if (field_bytes_left_next == 32'd0) begin
          do_finish = 1'b1;
          fin_span  = held_second_span_next;
        end
      end
      PH_WORD: begin
        if (field_bytes_left_next == 32'd0) begin
          do_finish = 1'b1;
          fin_word  = field_shift_next;
        end
      end
      PH_TAIL: begin
        if (position_next == entry_length_next) begin
          do_ok = 1'b1;
          ph    = PH_IDLE;
        end
      end
      PH_IDLE: ;
      default: ph = PH_DROP;
    endcase

    if (do_after) begin
      case (current_op_next)
        OP_DEL: do_finish = 1'b1;
        OP_DEL_SPAN: begin
          if (fits2) begin
            field_shift_next = '0; field_bytes_left_next = 32'd2; ph = PH_LEN2;
          end else do_finish = 1'b1;
        end
        OP_PUT: begin
          if (fits4) begin
            field_shift_next = '0; field_bytes_left_next = 32'd4; ph = PH_VLEN;
          end else do_finish = 1'b1;
        end
        default: begin
          if (fits8) begin
            field_shift_next = '0; field_bytes_left_next = 32'd8; ph = PH_WORD;
          end else do_finish = 1'b1;
        end
      endcase
    end

    if (do_finish) begin
      ops_left_next = ops_left_next - 16'd1;
      do_next       = 1'b1;
    end

    if (do_next) begin
      if (ops_left_next == 16'd0) begin
        if ({2'b00, position_next} + 34'(HASH_BYTES) == limit) ph = PH_TAIL;
        else do_bad = 1'b1;
      end else if ({2'b00, position_next} + 34'(HASH_BYTES) >= limit) begin
        do_bad = 1'b1;
      end else begin
        ph = PH_TYPE;
      end
    end

    if (do_bad) ph = PH_DROP;
    phase_next = ph;
  end

  always_comb begin
    rec_a = '0;
    if (do_hdr) begin
      rec_a.kind              = KIND_HEADER;
      rec_a.sequence_res      = held_sequence_next;
      rec_a.hdr_flags         = held_flags_count_next[23:16];
      rec_a.txn_id            = held_tx_id_next;
      rec_a.participant_count = held_flags_count_next[15:0];
      rec_a.op_total          = ops_left;
      if (i == 32'd13) rec_a.op_total = {in_byte, ops_left[7:0]};
    end else if (do_finish) begin
      rec_a.kind          = KIND_OP;
      rec_a.op_kind       = current_op_next;
      rec_a.first_offset  = held_first_span_next[31:0];
      rec_a.first_length  = held_first_span_next[47:32];
      rec_a.second_offset = fin_span[31:0];
      rec_a.second_length = fin_span[63:32];
      rec_a.subtree_word  = fin_word;
    end else if (do_ok) begin
      rec_a.kind = KIND_OK;
    end
    have_a = do_hdr || do_finish || do_ok;

    rec_bad      = '0;
    rec_bad.kind = KIND_BAD;
    rec_b        = '0;

    push.count = 2'd0;
    push.r0    = rec_a;
    push.r1    = rec_b;
    if (have_a && do_bad) begin
      push.count = 2'd2;
      push.r1    = rec_bad;
    end else if (have_a) begin
      push.count = 2'd1;
    end else if (do_bad) begin
      push.count = 2'd1;
      push.r0    = rec_bad;
    end
    if (!take_word) push.count = 2'd0;
  end

endmodule

@@ rtl/lrop_queue.sv @@
// ----------------------------------------------------------------------------
// lrop_queue
// four-entry record queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module lrop_queue import lrop_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  output rec_t  head,
  input  logic  pop
);

  rec_t       mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count, count_next;

  assign room       = count <= 3'd2;
  assign head_valid = count != 3'd0;
  assign head       = mem[rptr];

  always_comb begin
    count_next = count + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wptr] <= push.r0;
    if (push.count == 2'd2) mem[wptr + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push.count;
      rptr  <= rptr + {1'b0, pop};
      count <= count_next;
    end
  end

endmodule

@@ rtl/lrop_back.sv @@
// ----------------------------------------------------------------------------
// lrop_back
// output stage: pulls records from the queue into the result register
// ----------------------------------------------------------------------------
module lrop_back import lrop_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  rec_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_rec <= head;
  end

endmodule
